@@ rtl/core/windowed_energy_detector_assert.svh @@
// assertion macros for the windowed energy detector checker
// expects clk_i and rst_ni in the scope of each use
`ifndef WINDOWED_ENERGY_DETECTOR_ASSERT_SVH
`define WINDOWED_ENERGY_DETECTOR_ASSERT_SVH

// same-cycle implication
`define WED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wed_pkg.sv @@
// shared constants and types for the windowed energy detector
// no dependencies
`timescale 1ns / 1ps

package wed_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int POWER_W        = 2 * SAMPLE_BITS;
  localparam int WIN_W          = 11;
  localparam int THR_W          = 32;
  localparam int SUM_W          = POWER_W + WIN_W;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 32;
  localparam int WINDOW_MAX_DEF = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

  // window control from the register block
  typedef struct packed {
    logic             clear;
    logic [WIN_W-1:0] win;
  } wed_ctrl_t;

endpackage

@@ rtl/core/windowed_energy_detector.sv @@
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample_i, sample_q
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: average_power, tuser: detected
// cfg       in   cfg_we_i (no back-pressure)    cfg_idx_i, cfg_data_i
//
// the front end takes a new sample only after committing the last one to the queue; the
// back end makes one quotient bit per cycle in the radix-2 divider, so that sets the rate
// a two-entry queue and the output register let front and back stall independently
// no memory clearing pass: a fill count masks history entries not yet written,
// so the block accepts samples straight out of reset and after a window write
// top level of the windowed energy detector; depends on wed_pkg, wed_front,
// wed_fifo and wed_back
`timescale 1ns / 1ps

module windowed_energy_detector import wed_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,  // [15:0] sample_i, [31:16] sample_q
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [POWER_W-1:0]      m_axis_tdata,  // [31:0] average_power
  output logic                    m_axis_tuser,  // [0] detected
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int WIN_LIMIT = (2 ** WIN_W) - 1;
  localparam int W_CAP     = (WINDOW_MAX > WIN_LIMIT) ? WIN_LIMIT : WINDOW_MAX;

  logic [THR_W-1:0] thr_q;
  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] win_eff;
  wed_ctrl_t        ctrl;

  logic             push, fifo_full, fifo_valid, pop;
  logic [SUM_W-1:0] push_sum, pop_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      win_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        REG_WINDOW:    win_q <= cfg_data_i[WIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // zero window means one, oversized window is capped at the memory depth or 2**WIN_W - 1, whichever is less
  assign win_eff = (win_q == '0) ? WIN_W'(1)
                 : ((win_q > WIN_W'(W_CAP)) ? WIN_W'(W_CAP) : win_q);

  assign ctrl.clear = cfg_we_i && (cfg_idx_i == REG_WINDOW);
  assign ctrl.win   = win_eff;

  wed_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i_i (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .sample_q_i (signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .push_o     (push),
    .push_sum_o (push_sum),
    .full_i     (fifo_full)
  );

  wed_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_sum),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (pop_sum)
  );

  wed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_eff),
    .thr_i       (thr_q),
    .pop_valid_i (fifo_valid),
    .pop_sum_i   (pop_sum),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_avg_o   (m_axis_tdata),
    .out_det_o   (m_axis_tuser)
  );

endmodule

@@ rtl/core/wed_front.sv @@
// front end: power calculation, history memory and running sum
// depends on wed_pkg
`timescale 1ns / 1ps

module wed_front import wed_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wed_ctrl_t                     ctrl_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  output logic                          push_o,
  output logic [SUM_W-1:0]              push_sum_o,
  input  logic                          full_i
);

  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int AW     = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 2;

  localparam logic FS_IDLE = 1'b0;
  localparam logic FS_CALC = 1'b1;

  logic                   state_q, state_d;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   old_ok_q;
  logic [POWER_W-1:0]     sq_i_q, sq_q_q, rd_q;
  logic [POWER_W-1:0]     hist_mem [WINDOW_MAX];

  logic [SAMPLE_BITS-1:0] raw_i, raw_q, mag_i, mag_q;
  logic [AW-1:0]          wp_ext, w_ext, leave_ext;
  logic [PTR_W-1:0]       leave;
  logic [POWER_W-1:0]     power;
  logic                   accept, commit;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == FS_IDLE);
  assign commit     = (state_q == FS_CALC) && !full_i;

  assign raw_i = sample_i_i;
  assign raw_q = sample_q_i;
  assign mag_i = raw_i[SAMPLE_BITS-1] ? (~raw_i + SAMPLE_BITS'(1)) : raw_i;
  assign mag_q = raw_q[SAMPLE_BITS-1] ? (~raw_q + SAMPLE_BITS'(1)) : raw_q;

  // entry that drops out of the window, modulo the memory depth
  assign wp_ext    = AW'(wp_q);
  assign w_ext     = AW'(ctrl_i.win);
  assign leave_ext = (wp_ext >= w_ext) ? (wp_ext - w_ext)
                                       : (wp_ext + AW'(WINDOW_MAX) - w_ext);
  assign leave     = leave_ext[PTR_W-1:0];

  assign power      = sq_i_q + sq_q_q;
  assign sum_d      = sum_q + SUM_W'(power) - (old_ok_q ? SUM_W'(rd_q) : '0);
  assign push_o     = commit;
  assign push_sum_o = sum_d;

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          state_d = FS_CALC;
        end
      end
      FS_CALC: begin
        if (commit) begin
          state_d = FS_IDLE;
          wp_d    = (wp_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_q + PTR_W'(1);
          if (fill_q != FILL_W'(WINDOW_MAX)) begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FS_IDLE;
      wp_q     <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      old_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_i.clear) begin
        wp_q   <= '0;
        fill_q <= '0;
        sum_q  <= '0;
      end else begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
        if (commit) begin
          sum_q <= sum_d;
        end
      end
      // entries never written since the last clear read as zero
      if (accept) begin
        old_ok_q <= (AW'(fill_q) >= w_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_i_q <= POWER_W'(mag_i) * POWER_W'(mag_i);
      sq_q_q <= POWER_W'(mag_q) * POWER_W'(mag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= hist_mem[leave];
    end
    if (commit) begin
      hist_mem[wp_q] <= power;
    end
  end

endmodule

@@ rtl/core/wed_fifo.sv @@
// two-entry queue of running sums between front and back end
// depends on wed_pkg
`timescale 1ns / 1ps

module wed_fifo import wed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [SUM_W-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [SUM_W-1:0] data_o
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  logic [SUM_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      // depth is a power of two so the pointers wrap on their own
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/wed_back.sv @@
// back end: radix-2 divider for sum / window, threshold compare, output register
// depends on wed_pkg
`timescale 1ns / 1ps

module wed_back import wed_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WIN_W-1:0]   win_i,
  input  logic [THR_W-1:0]   thr_i,
  input  logic               pop_valid_i,
  input  logic [SUM_W-1:0]   pop_sum_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [POWER_W-1:0] out_avg_o,
  output logic               out_det_o
);

  localparam int CNT_W = $clog2(POWER_W + 1);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [WIN_W-1:0]   rem_q;
  logic [POWER_W-1:0] quo_q;
  logic               ovalid_q;
  logic [POWER_W-1:0] avg_q;
  logic               det_q;

  logic [WIN_W:0]     trial;
  logic               ge;
  logic [WIN_W-1:0]   step_rem;
  logic               done, xfer;

  // sum < win * 2**POWER_W, so the upper bits already sit below the divisor
  assign trial    = {rem_q, quo_q[POWER_W-1]};
  assign ge       = (trial >= {1'b0, win_i});
  assign step_rem = ge ? WIN_W'(trial - {1'b0, win_i}) : trial[WIN_W-1:0];

  assign done  = busy_q && (cnt_q == CNT_W'(POWER_W));
  assign xfer  = done && (!ovalid_q || out_ready_i);
  assign pop_o = !busy_q && pop_valid_i;

  assign out_valid_o = ovalid_q;
  assign out_avg_o   = avg_q;
  assign out_det_o   = det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (xfer) begin
        busy_q <= 1'b0;
      end else if (busy_q && !done) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (xfer) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q <= pop_sum_i[SUM_W-1:POWER_W];
      quo_q <= pop_sum_i[POWER_W-1:0];
    end else if (busy_q && !done) begin
      rem_q <= step_rem;
      quo_q <= {quo_q[POWER_W-2:0], ge};
    end
    if (xfer) begin
      avg_q <= quo_q;
      det_q <= (quo_q >= thr_i);
    end
  end

endmodule

@@ rtl/core/wed_checker.sv @@
// port-level checks for the windowed energy detector, bound to the top level
// depends on wed_pkg and windowed_energy_detector_assert.svh
`timescale 1ns / 1ps
`include "windowed_energy_detector_assert.svh"

module wed_checker import wed_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [POWER_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  logic             in_acc, out_acc, out_stall;
  logic [POWER_W:0] out_bus;
  logic [2:0]       pend_q;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bus   = {m_axis_tuser, m_axis_tdata};

  // transactions taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  `WED_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_bus), "stalled result moved")
  `WED_ASSERT_NXT(a_one_at_a_time, in_acc, !s_axis_tready, "second sample taken too early")
  `WED_ASSERT_IMP(a_no_phantom, m_axis_tvalid, pend_q != 3'd0, "result with no sample outstanding")
  `WED_ASSERT_IMP(a_avg_range, m_axis_tvalid, m_axis_tdata <= 32'h8000_0000, "average above peak")

endmodule

bind windowed_energy_detector wed_checker u_wed_checker (.*);
